// ----- hdl/uqpd_pkg.sv -----
package uqpd_pkg;

	localparam int unsigned MaxResults = 4;

	typedef enum logic [2:0] {
		KIND_DATA     = 3'd0,
		KIND_PATH_END = 3'd1,
		KIND_KEY_END  = 3'd2,
		KIND_PAIR_END = 3'd3,
		KIND_OK       = 3'd4,
		KIND_ERROR    = 3'd5
	} kind_t;

	localparam logic [1:0] SEG_PATH  = 2'd0;
	localparam logic [1:0] SEG_KEY   = 2'd1;
	localparam logic [1:0] SEG_VALUE = 2'd2;

	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_HI   = 2'd1;
	localparam logic [1:0] ESC_LO   = 2'd2;

	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_AMP      = 8'h26;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_EQUAL    = 8'h3D;
	localparam logic [7:0] CH_PERCENT  = 8'h25;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_SPACE    = 8'h20;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  segment;
		logic [7:0]  out_byte;
		logic        run_last;
	} result_t;

	typedef struct packed {
		logic [1:0] seg;
		logic [1:0] esc;
		logic [3:0] hi;
		logic       pair_open;
		logic       skip;
	} state_t;

	localparam state_t STATE_RESET = '{
		seg: SEG_PATH, esc: ESC_NONE, hi: 4'd0, pair_open: 1'b0, skip: 1'b0
	};

	typedef struct packed {
		result_t [MaxResults-1:0] res;
		logic [2:0]               cnt;
	} dec_out_t;

	function automatic result_t mk_result(kind_t k, logic [1:0] seg, logic [7:0] b);
		result_t r;
		r.kind     = k;
		r.segment  = seg;
		r.out_byte = b;
		r.run_last = 1'b0;
		return r;
	endfunction

	// Returns {is_hex, nibble}.
	function automatic logic [4:0] hex_digit(logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

endpackage

// ----- hdl/uqpd_in_if.sv -----
interface uqpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] uri_byte;
	logic       uri_last;

	modport source (output valid, output uri_byte, output uri_last, input ready);
	modport sink (input valid, input uri_byte, input uri_last, output ready);
endinterface

// ----- hdl/uqpd_out_if.sv -----
interface uqpd_out_if;
	logic               valid;
	logic               ready;
	uqpd_pkg::kind_t    kind;
	logic [1:0]         segment;
	logic [7:0]         out_byte;
	logic               run_last;

	modport source (output valid, output kind, output segment, output out_byte,
		output run_last, input ready);
	modport sink (input valid, input kind, input segment, input out_byte,
		input run_last, output ready);
endinterface

// ----- hdl/uri_query_percent_decoder.sv -----
// URI splitter and percent decoder.
// The uri channel takes one raw byte of the request target per transaction, with
// uri_last set on the final byte. The result channel gives decoded data bytes tagged
// with their segment (path, key or value) and boundary markers: path end, key end,
// pair end, and either URI ok or error to close each URI. run_last marks the final
// result caused by one input byte; a byte may cause no result at all.
// A byte accepted into the input register is decoded combinationally and loaded into
// the four-entry result buffer once the buffer is free, where its first result is
// presented. Throughput is one byte per cycle while each byte causes at most one
// result and the receiver is ready; otherwise the next byte waits in the input
// register until the buffer drains to its last entry.
// After an error, the remaining bytes of that URI are accepted and dropped.
// Reset clears the parser state to the start of a URI and empties both registers.
// When the receiver stalls, results hold in the buffer and the input stalls once
// the input register is occupied as well; no transaction is lost.
module uri_query_percent_decoder (
	input  logic       clk,
	input  logic       arst_n,
	uqpd_in_if.sink    uri,
	uqpd_out_if.source result
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	uqpd_pkg::state_t    st_q;
	uqpd_pkg::state_t    st_next;
	uqpd_pkg::dec_out_t  dec;
	logic                buf_free;
	logic                fire;

	assign fire      = valid_s1 && buf_free;
	assign uri.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= uqpd_pkg::STATE_RESET;
		end else begin
			if (uri.ready) valid_s1 <= uri.valid;
			if (fire) st_q <= st_next;
		end
	end

	always_ff @(posedge clk) begin
		if (uri.valid && uri.ready) begin
			byte_s1 <= uri.uri_byte;
			last_s1 <= uri.uri_last;
		end
	end

	uqpd_decode u_decode (
		.st   (st_q),
		.b    (byte_s1),
		.last (last_s1),
		.ns   (st_next),
		.dout (dec)
	);

	uqpd_result_buf u_result_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.din    (dec),
		.free   (buf_free),
		.result (result)
	);

endmodule

// ----- hdl/uqpd_decode.sv -----
module uqpd_decode (
	input  uqpd_pkg::state_t   st,
	input  logic [7:0]         b,
	input  logic               last,
	output uqpd_pkg::state_t   ns,
	output uqpd_pkg::dec_out_t dout
);

	always_comb begin
		logic [2:0] n;
		logic [2:0] lst;
		logic       bad;
		logic [4:0] hx;
		logic [7:0] plain;

		ns = st;
		n = 3'd0;
		lst = 3'd0;
		bad = 1'b0;
		dout = '0;
		hx = uqpd_pkg::hex_digit(b);
		plain = (b == uqpd_pkg::CH_PLUS) ? uqpd_pkg::CH_SPACE : b;

		if (st.skip) begin
			if (last) ns = uqpd_pkg::STATE_RESET;
		end else begin
			if (st.esc != uqpd_pkg::ESC_NONE) begin
				if (!hx[4]) begin
					bad = 1'b1;
				end else if (st.esc == uqpd_pkg::ESC_HI) begin
					ns.hi = hx[3:0];
					ns.esc = uqpd_pkg::ESC_LO;
				end else begin
					dout.res[n[1:0]] = uqpd_pkg::mk_result(uqpd_pkg::KIND_DATA, st.seg,
						{st.hi, hx[3:0]});
					n = n + 3'd1;
					ns.esc = uqpd_pkg::ESC_NONE;
					ns.hi = 4'd0;
				end
			end else if (st.seg == uqpd_pkg::SEG_PATH) begin
				if (b == uqpd_pkg::CH_QUESTION) begin
					dout.res[n[1:0]] = uqpd_pkg::mk_result(uqpd_pkg::KIND_PATH_END, 2'd0, 8'd0);
					n = n + 3'd1;
					ns.seg = uqpd_pkg::SEG_KEY;
					ns.pair_open = 1'b0;
				end else if (b == uqpd_pkg::CH_PERCENT) begin
					ns.esc = uqpd_pkg::ESC_HI;
				end else begin
					dout.res[n[1:0]] = uqpd_pkg::mk_result(uqpd_pkg::KIND_DATA, st.seg, plain);
					n = n + 3'd1;
				end
			end else begin
				if (b == uqpd_pkg::CH_AMP || b == uqpd_pkg::CH_SEMI) begin
					if (ns.pair_open) begin
						if (ns.seg == uqpd_pkg::SEG_KEY) begin
							dout.res[n[1:0]] = uqpd_pkg::mk_result(uqpd_pkg::KIND_KEY_END,
								2'd0, 8'd0);
							n = n + 3'd1;
						end
						dout.res[n[1:0]] = uqpd_pkg::mk_result(uqpd_pkg::KIND_PAIR_END,
							2'd0, 8'd0);
						n = n + 3'd1;
					end
					ns.pair_open = 1'b0;
					ns.seg = uqpd_pkg::SEG_KEY;
				end else if (b == uqpd_pkg::CH_EQUAL && st.seg == uqpd_pkg::SEG_KEY) begin
					dout.res[n[1:0]] = uqpd_pkg::mk_result(uqpd_pkg::KIND_KEY_END, 2'd0, 8'd0);
					n = n + 3'd1;
					ns.seg = uqpd_pkg::SEG_VALUE;
					ns.pair_open = 1'b1;
				end else if (b == uqpd_pkg::CH_PERCENT) begin
					ns.esc = uqpd_pkg::ESC_HI;
					ns.pair_open = 1'b1;
				end else begin
					dout.res[n[1:0]] = uqpd_pkg::mk_result(uqpd_pkg::KIND_DATA, st.seg, plain);
					n = n + 3'd1;
					ns.pair_open = 1'b1;
				end
			end

			// On the last byte, close whatever is still open and report the outcome.
			if (!bad && last) begin
				if (ns.esc != uqpd_pkg::ESC_NONE) begin
					bad = 1'b1;
				end else begin
					if (ns.seg == uqpd_pkg::SEG_PATH) begin
						dout.res[n[1:0]] = uqpd_pkg::mk_result(uqpd_pkg::KIND_PATH_END,
							2'd0, 8'd0);
						n = n + 3'd1;
					end else if (ns.pair_open) begin
						if (ns.seg == uqpd_pkg::SEG_KEY) begin
							dout.res[n[1:0]] = uqpd_pkg::mk_result(uqpd_pkg::KIND_KEY_END,
								2'd0, 8'd0);
							n = n + 3'd1;
						end
						dout.res[n[1:0]] = uqpd_pkg::mk_result(uqpd_pkg::KIND_PAIR_END,
							2'd0, 8'd0);
						n = n + 3'd1;
					end
					dout.res[n[1:0]] = uqpd_pkg::mk_result(uqpd_pkg::KIND_OK, 2'd0, 8'd0);
					n = n + 3'd1;
					ns = uqpd_pkg::STATE_RESET;
				end
			end

			if (bad) begin
				dout.res[n[1:0]] = uqpd_pkg::mk_result(uqpd_pkg::KIND_ERROR, 2'd0, 8'd0);
				n = n + 3'd1;
				ns = uqpd_pkg::STATE_RESET;
				ns.skip = !last;
			end
		end

		if (n != 3'd0) begin
			lst = n - 3'd1;
			dout.res[lst[1:0]].run_last = 1'b1;
		end
		dout.cnt = n;
	end

endmodule

// ----- hdl/uqpd_result_buf.sv -----
module uqpd_result_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  uqpd_pkg::dec_out_t din,
	output logic               free,
	uqpd_out_if.source         result
);

	uqpd_pkg::result_t [uqpd_pkg::MaxResults-1:0] entries_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign result.valid    = (cnt_q != 3'd0);
	assign pop             = result.valid && result.ready;
	assign free            = (cnt_q == 3'd0) || (cnt_q == 3'd1 && pop);
	assign result.kind     = entries_q[0].kind;
	assign result.segment  = entries_q[0].segment;
	assign result.out_byte = entries_q[0].out_byte;
	assign result.run_last = entries_q[0].run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= din.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// The head entry is always the next transaction; later entries move up on each pop.
	always_ff @(posedge clk) begin
		if (load) begin
			entries_q <= din.res;
		end else if (pop) begin
			for (int i = 0; i < uqpd_pkg::MaxResults - 1; i++) begin
				entries_q[i] <= entries_q[i+1];
			end
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 3'd0 || (cnt_q == 3'd1 && pop)))
		else $error("result buffer loaded while holding results");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(uqpd_pkg::MaxResults))
		else $error("result count out of range");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !result.run_last |=> cnt_q != 3'd0)
		else $error("run ended without a run_last result");

	a_marker_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind != uqpd_pkg::KIND_DATA |->
		result.segment == 2'd0 && result.out_byte == 8'd0)
		else $error("marker carries segment or byte");

	a_data_segment: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind == uqpd_pkg::KIND_DATA |-> result.segment != 2'd3)
		else $error("data tagged with unused segment");

endmodule

// ----- test/uri_decode_scoreboard.sv -----
`timescale 1ns / 1ps

// Watches both channels, runs its own URI splitter and decoder on every byte the
// block accepts, and compares each result transaction with the oldest expected one.
module uri_decode_scoreboard (
	input  logic clk,
	input  logic arst_n,
	uqpd_in_if   uri,
	uqpd_out_if  result,
	output int   mismatches,
	output int   outstanding
);

	uqpd_pkg::state_t  parse;
	uqpd_pkg::result_t step_results[$];
	uqpd_pkg::result_t expected_results[$];

	function automatic int nibble_of(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic void add_result(uqpd_pkg::kind_t k, logic [1:0] seg, logic [7:0] b);
		uqpd_pkg::result_t r;
		if (step_results.size() >= uqpd_pkg::MaxResults) return;
		r.kind     = k;
		r.segment  = seg;
		r.out_byte = b;
		r.run_last = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void close_query_pair();
		if (parse.pair_open) begin
			if (parse.seg == uqpd_pkg::SEG_KEY)
				add_result(uqpd_pkg::KIND_KEY_END, uqpd_pkg::SEG_PATH, 8'h00);
			add_result(uqpd_pkg::KIND_PAIR_END, uqpd_pkg::SEG_PATH, 8'h00);
		end
		parse.pair_open = 1'b0;
		parse.seg = uqpd_pkg::SEG_KEY;
	endfunction

	function automatic void predict_decode(logic [7:0] b, logic last);
		logic bad;
		int   nib;
		bad = 1'b0;
		step_results.delete();
		if (parse.skip) begin
			if (last) parse = uqpd_pkg::STATE_RESET;
			return;
		end
		if (parse.esc != uqpd_pkg::ESC_NONE) begin
			nib = nibble_of(b);
			if (nib < 0) begin
				bad = 1'b1;
			end else if (parse.esc == uqpd_pkg::ESC_HI) begin
				parse.hi = 4'(nib);
				parse.esc = uqpd_pkg::ESC_LO;
			end else begin
				add_result(uqpd_pkg::KIND_DATA, parse.seg, {parse.hi, 4'(nib)});
				parse.esc = uqpd_pkg::ESC_NONE;
				parse.hi = 4'd0;
			end
		end else if (parse.seg == uqpd_pkg::SEG_PATH) begin
			if (b == uqpd_pkg::CH_QUESTION) begin
				add_result(uqpd_pkg::KIND_PATH_END, uqpd_pkg::SEG_PATH, 8'h00);
				parse.seg = uqpd_pkg::SEG_KEY;
				parse.pair_open = 1'b0;
			end else if (b == uqpd_pkg::CH_PERCENT) begin
				parse.esc = uqpd_pkg::ESC_HI;
			end else begin
				add_result(uqpd_pkg::KIND_DATA, parse.seg,
					b == uqpd_pkg::CH_PLUS ? uqpd_pkg::CH_SPACE : b);
			end
		end else begin
			if (b == uqpd_pkg::CH_AMP || b == uqpd_pkg::CH_SEMI) begin
				close_query_pair();
			end else if (b == uqpd_pkg::CH_EQUAL && parse.seg == uqpd_pkg::SEG_KEY) begin
				add_result(uqpd_pkg::KIND_KEY_END, uqpd_pkg::SEG_PATH, 8'h00);
				parse.seg = uqpd_pkg::SEG_VALUE;
				parse.pair_open = 1'b1;
			end else if (b == uqpd_pkg::CH_PERCENT) begin
				parse.esc = uqpd_pkg::ESC_HI;
				parse.pair_open = 1'b1;
			end else begin
				add_result(uqpd_pkg::KIND_DATA, parse.seg,
					b == uqpd_pkg::CH_PLUS ? uqpd_pkg::CH_SPACE : b);
				parse.pair_open = 1'b1;
			end
		end
		// A good last byte closes whatever is still open; a pending escape is an error.
		if (!bad && last) begin
			if (parse.esc != uqpd_pkg::ESC_NONE) begin
				bad = 1'b1;
			end else begin
				if (parse.seg == uqpd_pkg::SEG_PATH)
					add_result(uqpd_pkg::KIND_PATH_END, uqpd_pkg::SEG_PATH, 8'h00);
				else close_query_pair();
				add_result(uqpd_pkg::KIND_OK, uqpd_pkg::SEG_PATH, 8'h00);
				parse = uqpd_pkg::STATE_RESET;
			end
		end
		if (bad) begin
			add_result(uqpd_pkg::KIND_ERROR, uqpd_pkg::SEG_PATH, 8'h00);
			parse = uqpd_pkg::STATE_RESET;
			parse.skip = !last;
		end
		if (step_results.size() > 0) step_results[step_results.size() - 1].run_last = 1'b1;
		foreach (step_results[i]) expected_results.push_back(step_results[i]);
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void compare_result();
		uqpd_pkg::result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t ns: result with none expected, kind %0h segment %0h byte %0h last %0b",
				$time, result.kind, result.segment, result.out_byte, result.run_last);
			mismatches++;
			return;
		end
		want = expected_results.pop_front();
		check_field("kind", 8'(want.kind), 8'(result.kind));
		check_field("segment", 8'(want.segment), 8'(result.segment));
		check_field("out_byte", want.out_byte, result.out_byte);
		check_field("run_last", 8'(want.run_last), 8'(result.run_last));
	endfunction

	// Results are compared before the byte of the same edge is decoded, since a
	// byte never produces a result at the edge it is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			parse = uqpd_pkg::STATE_RESET;
			expected_results.delete();
		end else begin
			if (result.valid && result.ready) compare_result();
			if (uri.valid && uri.ready) predict_decode(uri.uri_byte, uri.uri_last);
		end
		outstanding <= expected_results.size();
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int    RandomBytes = 310;
	localparam int    HoldCycles  = 120;
	localparam int    CycleLimit  = 100000;
	localparam string HexChars    = "0123456789abcdefABCDEF";
	localparam string BadEscChars = "gG/:@`zZ %";

	logic clk;
	logic arst_n;

	uqpd_in_if  uri_ch ();
	uqpd_out_if result_ch ();

	int         mismatches;
	int         outstanding;
	int         bytes_sent;
	int         random_start;
	logic       quiet;
	logic       hold_off_req;
	logic       held;
	logic       paused;
	logic [7:0] uri_text[$];

	uri_query_percent_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.uri    (uri_ch),
		.result (result_ch)
	);

	uri_decode_scoreboard scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.uri         (uri_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("uri_query_percent_decoder verification failed");
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				result_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_off_req = 1'b0;
			end
			result_ch.ready <= quiet || $urandom_range(99) >= 7;
		end
	end

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = 8'($urandom_range(8'h21, 8'h7e));
		while (c == uqpd_pkg::CH_PERCENT || c == uqpd_pkg::CH_AMP ||
			c == uqpd_pkg::CH_SEMI || c == uqpd_pkg::CH_EQUAL ||
			c == uqpd_pkg::CH_QUESTION);
		return c;
	endfunction

	function automatic logic [7:0] separator();
		return $urandom_range(1) ? uqpd_pkg::CH_AMP : uqpd_pkg::CH_SEMI;
	endfunction

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) uri_text.push_back(s[i]);
	endtask

	// One path, key or value run: plain characters, '+', escapes, and the
	// characters that are plain data only in the query or in a value.
	task automatic append_run(int max_len, logic in_value, logic in_query);
		int n;
		int pick;
		n = $urandom_range(max_len);
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				uri_text.push_back(uqpd_pkg::CH_PERCENT);
				uri_text.push_back(HexChars[$urandom_range(HexChars.len() - 1)]);
				uri_text.push_back(HexChars[$urandom_range(HexChars.len() - 1)]);
			end else if (pick < 25) begin
				uri_text.push_back(uqpd_pkg::CH_PLUS);
			end else if (in_query && pick < 29) begin
				uri_text.push_back(uqpd_pkg::CH_QUESTION);
			end else if (in_value && pick < 33) begin
				uri_text.push_back(uqpd_pkg::CH_EQUAL);
			end else begin
				uri_text.push_back(plain_char());
			end
		end
	endtask

	task automatic build_wellformed();
		int pairs;
		append_run(6, 1'b0, 1'b0);
		if ($urandom_range(99) < 80) begin
			uri_text.push_back(uqpd_pkg::CH_QUESTION);
			pairs = $urandom_range(4);
			for (int i = 0; i < pairs; i++) begin
				if (i > 0 || $urandom_range(99) < 15) uri_text.push_back(separator());
				if ($urandom_range(99) < 10) uri_text.push_back(separator());
				append_run(4, 1'b0, 1'b1);
				if ($urandom_range(99) < 75) begin
					uri_text.push_back(uqpd_pkg::CH_EQUAL);
					append_run(5, 1'b1, 1'b1);
				end
			end
			if ($urandom_range(99) < 10) uri_text.push_back(separator());
		end
		if (uri_text.size() == 0) uri_text.push_back(plain_char());
	endtask

	// Plants a '%' at a random place, then a non-hex byte, a hex digit or nothing.
	task automatic break_escape();
		int pos;
		pos = $urandom_range(uri_text.size());
		uri_text.insert(pos, uqpd_pkg::CH_PERCENT);
		if ($urandom_range(99) < 70)
			uri_text.insert(pos + 1, BadEscChars[$urandom_range(BadEscChars.len() - 1)]);
		else if ($urandom_range(1))
			uri_text.insert(pos + 1, HexChars[$urandom_range(HexChars.len() - 1)]);
	endtask

	task automatic build_noise();
		int n;
		n = $urandom_range(1, 8);
		repeat (n) begin
			if ($urandom_range(99) < 30) uri_text.push_back(uqpd_pkg::CH_PERCENT);
			else uri_text.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic send_byte(logic [7:0] b, logic last);
		if (random_start >= 0) begin
			quiet = bytes_sent >= random_start + 130 && bytes_sent < random_start + 210;
			if (!held && bytes_sent >= random_start + 40) begin
				held = 1'b1;
				hold_off_req = 1'b1;
			end
			if (!paused && bytes_sent >= random_start + 230) begin
				paused = 1'b1;
				uri_ch.valid <= 1'b0;
				do @(negedge clk); while (outstanding != 0);
				@(posedge clk);
			end
		end
		if (!quiet && $urandom_range(99) < 7) begin
			uri_ch.valid <= 1'b0;
			@(posedge clk);
		end
		uri_ch.valid <= 1'b1;
		uri_ch.uri_byte <= b;
		uri_ch.uri_last <= last;
		@(posedge clk);
		while (!uri_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_uri();
		foreach (uri_text[i]) send_byte(uri_text[i], i == uri_text.size() - 1);
		uri_text.delete();
	endtask

	initial begin
		int pick;
		arst_n <= 1'b0;
		uri_ch.valid <= 1'b0;
		uri_ch.uri_byte <= 8'h00;
		uri_ch.uri_last <= 1'b0;
		bytes_sent = 0;
		random_start = -1;
		quiet = 1'b0;
		hold_off_req = 1'b0;
		held = 1'b0;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty path and empty query.
		push_text("?");
		send_uri();
		// Escapes in both cases, '+', an empty pair, '=' inside a value, a ';'
		// separator, '?' as query data and a key without '=' on the last byte.
		push_text("%Ff+?&a=b=%4a;?");
		send_uri();
		// Bad hex digit, then the rest of the URI is dropped.
		push_text("%Gxy");
		send_uri();
		// Escape cut off by the end of the URI.
		push_text("%4");
		send_uri();
		// Byte extremes in the path; path end comes with the last byte.
		uri_text.push_back(8'h00);
		uri_text.push_back(8'hFF);
		send_uri();

		random_start = bytes_sent;
		while (bytes_sent < random_start + RandomBytes) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				build_noise();
			end else begin
				build_wellformed();
				if (pick < 25) break_escape();
			end
			send_uri();
		end
		uri_ch.valid <= 1'b0;
		quiet = 1'b0;

		do @(negedge clk); while (outstanding != 0);
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("uri_query_percent_decoder verification clean");
		end else begin
			$display("uri_query_percent_decoder verification failed");
		end
		$finish;
	end

endmodule

// ----- uri_query_percent_decoder.f -----
hdl/uqpd_pkg.sv
hdl/uqpd_in_if.sv
hdl/uqpd_out_if.sv
hdl/uqpd_decode.sv
hdl/uqpd_result_buf.sv
hdl/uri_query_percent_decoder.sv
test/uri_decode_scoreboard.sv
test/testbench.sv
